>>> hw/rtl/vn_pkg.sv
// Package with the shared widths and transfer types of the vector normaliser.
package vn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;
    localparam int UNIT_WIDTH  = 16;
    localparam int LEN_WIDTH   = 16;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [UNIT_WIDTH-1:0] unit_x;
        logic signed [UNIT_WIDTH-1:0] unit_y;
        logic signed [UNIT_WIDTH-1:0] unit_z;
        logic        [LEN_WIDTH-1:0]  vec_length;
        logic                         zero_vector;
    } out_t;

endpackage

>>> hw/rtl/vector3_normalize.sv
// Vector normaliser: squares, sum, square root pipeline, dividers and output register,
// with one register stage per square root digit and one per quotient bit.
// Throughput is one vector per cycle; the square root and the three dividers
// are fully pipelined, and the whole pipeline holds when the output stalls.
// Synchronous active-low reset clears all valid bits; data registers keep
// their contents.
module vector3_normalize #(
    parameter int FRAC_BITS = vn_pkg::FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  vn_pkg::in_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output vn_pkg::out_t m_data
);

    localparam int W      = vn_pkg::COORD_WIDTH;
    localparam int SUM_W  = 2 * W + 2;
    localparam int ROOT_W = W + 1;
    localparam int NUM_W  = W + FRAC_BITS;
    localparam int QW     = FRAC_BITS + 1;
    localparam int CMP_W  = NUM_W + 2;
    localparam int UW     = vn_pkg::UNIT_WIDTH;
    localparam int LW     = vn_pkg::LEN_WIDTH;
    localparam int EW     = (QW + 1 > UW) ? QW + 1 : UW;
    localparam int RW     = (ROOT_W > LW) ? ROOT_W : LW;

    // The whole pipeline moves together whenever the output slot can take data.
    logic adv;
    logic out_valid_reg;
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage one: magnitudes, signs and squares.
    logic [W-1:0]   in_c [3];
    logic [W-1:0]   mag_next [3];
    logic [W-1:0]   mag1_reg [3];
    logic [2*W-1:0] sq1_reg  [3];
    logic [2:0]     neg1_reg;
    logic           v1_reg;

    assign in_c[0] = s_data.in_x;
    assign in_c[1] = s_data.in_y;
    assign in_c[2] = s_data.in_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = in_c[i][W-1] ? (~in_c[i] + W'(1)) : in_c[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= mag_next[i];
                sq1_reg[i]  <= (2*W)'(mag_next[i]) * (2*W)'(mag_next[i]);
                neg1_reg[i] <= in_c[i][W-1];
            end
        end
    end

    // Stage two: sum of squares into the head of the square root pipeline.
    logic [SUM_W-1:0] rt_n_reg    [ROOT_W+1];
    logic [SUM_W-1:0] rt_root_reg [ROOT_W+1];
    logic [W-1:0]     rt_mag_reg  [ROOT_W+1][3];
    logic [2:0]       rt_neg_reg  [ROOT_W+1];
    logic             rt_zero_reg [ROOT_W+1];
    logic             rt_v_reg    [ROOT_W+1];
    logic [SUM_W-1:0] sum_next;

    assign sum_next = SUM_W'(sq1_reg[0]) + SUM_W'(sq1_reg[1]) + SUM_W'(sq1_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_v_reg[0] <= 1'b0;
        end else if (adv) begin
            rt_v_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rt_n_reg[0]    <= sum_next;
            rt_root_reg[0] <= '0;
            rt_mag_reg[0]  <= mag1_reg;
            rt_neg_reg[0]  <= neg1_reg;
            rt_zero_reg[0] <= (sum_next == '0);
        end
    end

    // Square root: one result digit per stage, bit weight falling by four.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] n_next;
        logic [SUM_W-1:0] root_next;

        always_comb begin
            trial = rt_root_reg[k] + BIT;
            if (rt_n_reg[k] >= trial) begin
                n_next    = rt_n_reg[k] - trial;
                root_next = (rt_root_reg[k] >> 1) + BIT;
            end else begin
                n_next    = rt_n_reg[k];
                root_next = rt_root_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                rt_v_reg[k+1] <= rt_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rt_n_reg[k+1]    <= n_next;
                rt_root_reg[k+1] <= root_next;
                rt_mag_reg[k+1]  <= rt_mag_reg[k];
                rt_neg_reg[k+1]  <= rt_neg_reg[k];
                rt_zero_reg[k+1] <= rt_zero_reg[k];
            end
        end
    end

    // Dividers: three restoring dividers, one quotient bit per stage each.
    logic [NUM_W-1:0]  dv_rem_reg  [QW][3];
    logic [QW-1:0]     dv_q_reg    [QW][3];
    logic [ROOT_W-1:0] dv_len_reg  [QW];
    logic [2:0]        dv_neg_reg  [QW];
    logic              dv_zero_reg [QW];
    logic              dv_v_reg    [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int SH = QW - 1 - j;
        logic [NUM_W-1:0]  rem_in  [3];
        logic [QW-1:0]     q_in    [3];
        logic [ROOT_W-1:0] len_in;
        logic [2:0]        neg_in;
        logic              zero_in;
        logic              v_in;
        logic [CMP_W-1:0]  dsr;
        logic [NUM_W-1:0]  rem_next [3];
        logic [QW-1:0]     q_next   [3];

        if (j == 0) begin : g_head
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = NUM_W'(rt_mag_reg[ROOT_W][i]) << FRAC_BITS;
                    q_in[i]   = '0;
                end
            end
            assign len_in  = rt_root_reg[ROOT_W][ROOT_W-1:0];
            assign neg_in  = rt_neg_reg[ROOT_W];
            assign zero_in = rt_zero_reg[ROOT_W];
            assign v_in    = rt_v_reg[ROOT_W];
        end else begin : g_body
            assign rem_in  = dv_rem_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign len_in  = dv_len_reg[j-1];
            assign neg_in  = dv_neg_reg[j-1];
            assign zero_in = dv_zero_reg[j-1];
            assign v_in    = dv_v_reg[j-1];
        end

        assign dsr = CMP_W'(len_in) << SH;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                q_next[i] = q_in[i];
                if (CMP_W'(rem_in[i]) >= dsr) begin
                    rem_next[i]   = rem_in[i] - dsr[NUM_W-1:0];
                    q_next[i][SH] = 1'b1;
                end else begin
                    rem_next[i] = rem_in[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
                dv_len_reg[j]  <= len_in;
                dv_neg_reg[j]  <= neg_in;
                dv_zero_reg[j] <= zero_in;
            end
        end
    end

    // Output register: sign restore, zero vector forcing and field truncation.
    logic [EW-1:0]  unit_full [3];
    logic [RW-1:0]  len_full;
    vn_pkg::out_t   out_next;
    vn_pkg::out_t   out_data_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unit_full[i] = EW'(dv_q_reg[QW-1][i]);
            if (dv_neg_reg[QW-1][i]) begin
                unit_full[i] = ~unit_full[i] + EW'(1);
            end
            if (dv_zero_reg[QW-1]) begin
                unit_full[i] = '0;
            end
        end
        len_full = dv_zero_reg[QW-1] ? '0 : RW'(dv_len_reg[QW-1]);
        out_next.unit_x      = unit_full[0][UW-1:0];
        out_next.unit_y      = unit_full[1][UW-1:0];
        out_next.unit_z      = unit_full[2][UW-1:0];
        out_next.vec_length  = len_full[LW-1:0];
        out_next.zero_vector = dv_zero_reg[QW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_v_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> hw/rtl/vn_checker.sv
// Port checker for the vector normaliser, bound to the top level.
module vn_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_valid,
    input logic         m_ready,
    input vn_pkg::out_t m_data
);

    // A stalled result transfer holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A zero vector result carries only zeros.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_vector |->
            m_data.unit_x == '0 && m_data.unit_y == '0 &&
            m_data.unit_z == '0 && m_data.vec_length == '0)
        else $error("zero vector result not cleared");

    // Any other vector has a non-zero length.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_vector |-> m_data.vec_length != '0)
        else $error("non-zero vector with zero length");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
